// ===== rtl/core/gtcb_pkg.sv =====
// Shared types and constants for the complex gammatone band-pass filter.
// Used by the cell, controller, output scaler and top level.
`timescale 1ns / 1ps

package gtcb_pkg;

    // Stage state is a signed 64-bit word whose LSB weighs 2^-31.
    localparam int STATE_W    = 64;
    localparam int HALF_W     = 32;
    localparam int COEF_W     = 24;
    localparam int OP_W       = HALF_W + 1;
    localparam int MUL_W      = OP_W + COEF_W;
    localparam int PROD_W     = MUL_W + 1;
    localparam int WIDE_W     = PROD_W + HALF_W;
    localparam int COEF_FRAC  = 23;
    localparam int GAIN_FRAC  = 22;
    localparam int PART_COUNT = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 24'd4194304;
    localparam logic [STATE_W-1:0]    STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic [STATE_W-1:0]    STATE_MIN  = {1'b1, {(STATE_W-1){1'b0}}};

    // Partial product slots of one cell: real/imag term, low/high state half.
    typedef enum logic [1:0] {
        PART_RE_LO = 2'd0,
        PART_RE_HI = 2'd1,
        PART_IM_LO = 2'd2,
        PART_IM_HI = 2'd3
    } t_part;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POLE_REAL   = 2'd0,
        CFG_POLE_IMAG   = 2'd1,
        CFG_OUTPUT_GAIN = 2'd2
    } t_cfg_addr;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_MUL    = 3'd1,
        ST_TERM   = 3'd2,
        ST_CHAIN  = 3'd3,
        ST_COMMIT = 3'd4,
        ST_OUT    = 3'd5
    } t_state;

    typedef struct packed {
        logic  mul_en;
        t_part mul_sel;
        logic  dif_en;
        t_part dif_sel;
        logic  term_en;
        logic  chain_en;
        logic  commit;
        logic  out_mul_en;
        logic  out_load;
    } t_ctl;

endpackage

// ===== rtl/core/gtcb_cell.sv =====
// One complex one-pole stage of the cascade: holds its state, forms its pole term
// with two 33x24 multipliers over four steps, and adds it to the neighbor's value.
// Depends on gtcb_pkg.
`timescale 1ns / 1ps

module gtcb_cell import gtcb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic signed [COEF_W-1:0]  i_pole_real,
    input  logic signed [COEF_W-1:0]  i_pole_imag,
    input  logic signed [STATE_W-1:0] i_re,
    input  logic signed [STATE_W-1:0] i_im,
    output logic signed [STATE_W-1:0] o_re,
    output logic signed [STATE_W-1:0] o_im
);

    localparam int Q_W = WIDE_W - COEF_FRAC;

    logic signed [STATE_W-1:0] r_sr;
    logic signed [STATE_W-1:0] r_si;
    logic signed [MUL_W-1:0]   r_m0;
    logic signed [MUL_W-1:0]   r_m1;
    logic        [PROD_W-1:0]  r_part [PART_COUNT];
    logic signed [STATE_W-1:0] r_tr;
    logic signed [STATE_W-1:0] r_ti;
    logic signed [STATE_W-1:0] r_re;
    logic signed [STATE_W-1:0] r_im;

    logic signed [OP_W-1:0]    w_op_a;
    logic signed [OP_W-1:0]    w_op_b;
    logic signed [MUL_W-1:0]   w_m0;
    logic signed [MUL_W-1:0]   w_m1;
    logic        [PROD_W-1:0]  w_m0_x;
    logic        [PROD_W-1:0]  w_m1_x;
    logic        [PROD_W-1:0]  w_dif;

    // floor((hi * 2^32 + lo) / 2^23), saturated to the state width.
    function automatic logic [STATE_W-1:0] term_scale(
        input logic [PROD_W-1:0] hi,
        input logic [PROD_W-1:0] lo
    );
        logic [WIDE_W-1:0] t;
        logic [Q_W-1:0]    q;
        logic [Q_W-STATE_W:0] top;
        t   = {hi, {HALF_W{1'b0}}} + {{(WIDE_W-PROD_W){lo[PROD_W-1]}}, lo};
        q   = t[WIDE_W-1:COEF_FRAC];
        top = q[Q_W-1:STATE_W-1];
        if (top == '0 || top == '1) begin
            return q[STATE_W-1:0];
        end
        return q[Q_W-1] ? STATE_MIN : STATE_MAX;
    endfunction

    function automatic logic [STATE_W-1:0] sat_add(
        input logic [STATE_W-1:0] a,
        input logic [STATE_W-1:0] b
    );
        logic [STATE_W:0] s;
        s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
        if (s[STATE_W] != s[STATE_W-1]) begin
            return s[STATE_W] ? STATE_MIN : STATE_MAX;
        end
        return s[STATE_W-1:0];
    endfunction

    // Low halves enter as unsigned, high halves keep the sign.
    always_comb begin
        unique case (i_ctl.mul_sel)
            PART_RE_LO: begin
                w_op_a = {1'b0, r_sr[HALF_W-1:0]};
                w_op_b = {1'b0, r_si[HALF_W-1:0]};
            end
            PART_RE_HI: begin
                w_op_a = {r_sr[STATE_W-1], r_sr[STATE_W-1:HALF_W]};
                w_op_b = {r_si[STATE_W-1], r_si[STATE_W-1:HALF_W]};
            end
            PART_IM_LO: begin
                w_op_a = {1'b0, r_si[HALF_W-1:0]};
                w_op_b = {1'b0, r_sr[HALF_W-1:0]};
            end
            PART_IM_HI: begin
                w_op_a = {r_si[STATE_W-1], r_si[STATE_W-1:HALF_W]};
                w_op_b = {r_sr[STATE_W-1], r_sr[STATE_W-1:HALF_W]};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_m0   = w_op_a * i_pole_real;
    assign w_m1   = w_op_b * i_pole_imag;
    assign w_m0_x = {r_m0[MUL_W-1], r_m0};
    assign w_m1_x = {r_m1[MUL_W-1], r_m1};

    always_comb begin
        unique case (i_ctl.dif_sel)
            PART_RE_LO, PART_RE_HI: w_dif = w_m0_x - w_m1_x;
            PART_IM_LO, PART_IM_HI: w_dif = w_m0_x + w_m1_x;
            default:                w_dif = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_m0 <= w_m0;
            r_m1 <= w_m1;
        end
        if (i_ctl.dif_en) begin
            r_part[i_ctl.dif_sel] <= w_dif;
        end
        if (i_ctl.term_en) begin
            r_tr <= term_scale(r_part[PART_RE_HI], r_part[PART_RE_LO]);
            r_ti <= term_scale(r_part[PART_IM_HI], r_part[PART_IM_LO]);
        end
        // The cascade settles one cell per cycle while the terms stay fixed.
        if (i_ctl.chain_en) begin
            r_re <= sat_add(i_re, r_tr);
            r_im <= sat_add(i_im, r_ti);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= '0;
            r_si <= '0;
        end else if (i_ctl.commit) begin
            r_sr <= r_re;
            r_si <= r_im;
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;

endmodule

// ===== rtl/core/gtcb_out.sv =====
// Output scaling: last stage real part times the normalization gain, shifted
// down to the sample format and clamped. Depends on gtcb_pkg.
`timescale 1ns / 1ps

module gtcb_out import gtcb_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  t_ctl                      i_ctl,
    input  logic signed [STATE_W-1:0] i_re,
    input  logic [CFG_DATA_W-1:0]     i_gain,
    output logic [SAMPLE_BITS-1:0]    o_sample
);

    localparam int OUT_SHIFT = GAIN_FRAC + HALF_W - SAMPLE_BITS;
    localparam int Y_W       = WIDE_W - OUT_SHIFT;

    logic signed [PROD_W-1:0] r_ph;
    logic signed [PROD_W-1:0] r_pl;

    logic signed [OP_W-1:0]         w_hi;
    logic signed [OP_W-1:0]         w_lo;
    logic signed [CFG_DATA_W:0]     w_gain;
    logic        [WIDE_W-1:0]       w_t;
    logic        [Y_W-1:0]          w_y;
    logic        [Y_W-SAMPLE_BITS:0] w_top;

    assign w_hi   = {i_re[STATE_W-1], i_re[STATE_W-1:HALF_W]};
    assign w_lo   = {1'b0, i_re[HALF_W-1:0]};
    assign w_gain = {1'b0, i_gain};

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_mul_en) begin
            r_ph <= w_hi * w_gain;
            r_pl <= w_lo * w_gain;
        end
    end

    assign w_t   = {r_ph, {HALF_W{1'b0}}} + {{(WIDE_W-PROD_W){r_pl[PROD_W-1]}}, r_pl};
    assign w_y   = w_t[WIDE_W-1:OUT_SHIFT];
    assign w_top = w_y[Y_W-1:SAMPLE_BITS-1];

    always_comb begin
        if (w_top == '0 || w_top == '1) begin
            o_sample = w_y[SAMPLE_BITS-1:0];
        end else if (w_y[Y_W-1]) begin
            o_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/core/gtcb_ctrl.sv =====
// Sequencer for the cell row: partial products, term scaling, cascade ripple,
// state update and output load. Depends on gtcb_pkg.
`timescale 1ns / 1ps

module gtcb_ctrl import gtcb_pkg::*; #(
    parameter int STAGE_COUNT = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_accept,
    input  logic i_out_free,
    output logic o_ready,
    output t_ctl o_ctl
);

    localparam int CNT_W = $clog2((STAGE_COUNT > PART_COUNT + 1) ? STAGE_COUNT
                                                                   : PART_COUNT + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_accept) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end
            end
            ST_MUL: begin
                if (r_cnt == CNT_W'(PART_COUNT)) begin
                    n_state = ST_TERM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_TERM: begin
                n_state = ST_CHAIN;
                n_cnt   = '0;
            end
            ST_CHAIN: begin
                if (r_cnt == CNT_W'(STAGE_COUNT - 1)) begin
                    n_state = ST_COMMIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_COMMIT: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Products of step k are registered first and then folded into partial slot k.
    always_comb begin
        o_ctl   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_MUL: begin
                o_ctl.mul_en  = (r_cnt != CNT_W'(PART_COUNT));
                o_ctl.mul_sel = t_part'(r_cnt[1:0]);
                o_ctl.dif_en  = (r_cnt != '0);
                o_ctl.dif_sel = t_part'(r_cnt[1:0] - 2'd1);
            end
            ST_TERM:  o_ctl.term_en = 1'b1;
            ST_CHAIN: o_ctl.chain_en = 1'b1;
            ST_COMMIT: begin
                o_ctl.commit     = 1'b1;
                o_ctl.out_mul_en = 1'b1;
            end
            ST_OUT:  o_ctl.out_load = i_out_free;
            default: o_ready = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/gammatone_complex_bandpass.sv =====
// Complex gammatone band-pass filter top level, of order STAGE_COUNT (default 4).
// Depends on gtcb_pkg, gtcb_ctrl, gtcb_cell and gtcb_out.
//
// Each input beat carries one signed sample; each output beat carries one signed,
// saturated band sample, one result per input. The filter is a row of STAGE_COUNT
// cells, one per complex pole stage. A sample is taken only after the last result
// is loaded: every cell forms its pole term over four steps of its two 33x24
// multipliers, then the cascade sum ripples through the row one cell per cycle,
// and the output gain product is registered. The result sits in an output
// register, and the next sample is accepted while it waits. Pole and gain
// registers are written through the plain write port; the user must write them
// only while no sample is in flight, as the block itself does not enforce it.
`timescale 1ns / 1ps

module gammatone_complex_bandpass import gtcb_pkg::*; #(
    parameter int STAGE_COUNT = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: sample_in.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0: sample_out.
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    input  logic                                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                  i_cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic signed [COEF_W-1:0]      r_pole_real;
    logic signed [COEF_W-1:0]      r_pole_imag;
    logic        [CFG_DATA_W-1:0]  r_output_gain;
    logic        [SAMPLE_BITS-1:0] r_sample;
    logic                          r_out_valid;
    logic        [SAMPLE_BITS-1:0] r_out_data;

    t_ctl                          w_ctl;
    logic                          w_ready;
    logic                          w_in_accept;
    logic                          w_out_free;
    logic        [SAMPLE_BITS-1:0] w_out_sample;
    logic signed [STATE_W-1:0]     w_re [STAGE_COUNT+1];
    logic signed [STATE_W-1:0]     w_im [STAGE_COUNT+1];

    assign w_in_accept = s_axis_tvalid && w_ready;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_real   <= '0;
            r_pole_imag   <= '0;
            r_output_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_POLE_REAL:   r_pole_real   <= i_cfg_wdata;
                CFG_POLE_IMAG:   r_pole_imag   <= i_cfg_wdata;
                CFG_OUTPUT_GAIN: r_output_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (w_ctl.out_load) begin
            r_out_data <= w_out_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    gtcb_ctrl #(
        .STAGE_COUNT (STAGE_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_out_free  (w_out_free),
        .o_ready     (w_ready),
        .o_ctl       (w_ctl)
    );

    // The sample enters the first cell in the state format, LSB at 2^-31.
    assign w_re[0] = {{(STATE_W-HALF_W){r_sample[SAMPLE_BITS-1]}}, r_sample,
                      {(HALF_W-SAMPLE_BITS){1'b0}}};
    assign w_im[0] = '0;

    for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_cell
        gtcb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_pole_real (r_pole_real),
            .i_pole_imag (r_pole_imag),
            .i_re        (w_re[g]),
            .i_im        (w_im[g]),
            .o_re        (w_re[g+1]),
            .o_im        (w_im[g+1])
        );
    end

    gtcb_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_re     (w_re[STAGE_COUNT]),
        .i_gain   (r_output_gain),
        .o_sample (w_out_sample)
    );

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);

endmodule

// ===== rtl/core/gtcb_checker.sv =====
// Port-level checks for the gammatone filter top level, bound to it below.
// Depends on gtcb_pkg only through the top level it watches.
`timescale 1ns / 1ps

module gtcb_checker #(
    parameter int TDATA_W = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    logic [2:0] r_pend;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = m_axis_tvalid && m_axis_tready;

    // Samples taken but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {2'b0, w_in_beat} - {2'b0, w_out_beat};
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != 3'd0)
        else $error("output beat without a pending sample");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("more than two samples outstanding");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !s_axis_tready)
        else $error("new sample taken while one is in the cell row");

endmodule

bind gammatone_complex_bandpass gtcb_checker #(
    .TDATA_W (((SAMPLE_BITS + 7) / 8) * 8)
) u_gtcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
